/* rtl/itrd_pkg.sv */
// Shared constants, control-word types and status bundle for the radix digit converter.
// Used by the sequencer, the datapath and the top level.
package itrd_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int MAG_W         = VALUE_WIDTH - 1;
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = (MAG_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int QUO_W         = DIV_STEPS * BITS_PER_STEP;
    localparam int DIVC_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int DIG_MAX       = MAG_W;
    localparam int ADDR_W        = (DIG_MAX > 1) ? $clog2(DIG_MAX) : 1;
    localparam int SP_W          = $clog2(DIG_MAX + 1);
    localparam int BASE_W        = 5;
    localparam int REM_W         = 5;
    localparam int DIGIT_W       = 4;
    localparam int STEP_W        = 3;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

    localparam logic [VALUE_WIDTH-1:0] SIGN_ONLY = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] POS_MAX   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DIV,
        OP_PUSH,
        OP_POP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_IDLE,
        C_DIV_MORE,
        C_QUO_NZ,
        C_STACK_EMPTY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic div_last;
        logic quo_nz;
        logic stack_nz;
    } t_stat;

endpackage

/* rtl/itrd_seq.sv */
// Microcode sequencer: step counter, control store and jump condition select.
// Depends on itrd_pkg for control-word and status types.
module itrd_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  itrd_pkg::t_stat i_stat,
    output itrd_pkg::t_op  o_op,
    output logic           o_busy,
    output logic           o_load
);
    import itrd_pkg::*;

    localparam logic [STEP_W-1:0] ST_IDLE = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_DIV  = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_PUSH = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_POP  = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_EMIT = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_POP2 = STEP_W'(5);

    // Control store: jump to target when the condition holds, else fall through.
    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] s);
        t_ctrl w;
        unique case (s)
            ST_IDLE: w = '{OP_NOP,  C_IDLE,        ST_IDLE};
            ST_DIV:  w = '{OP_DIV,  C_DIV_MORE,    ST_DIV};
            ST_PUSH: w = '{OP_PUSH, C_QUO_NZ,      ST_DIV};
            ST_POP:  w = '{OP_POP,  C_NONE,        ST_IDLE};
            ST_EMIT: w = '{OP_EMIT, C_STACK_EMPTY, ST_IDLE};
            ST_POP2: w = '{OP_POP,  C_ALWAYS,      ST_EMIT};
            default: w = '{OP_NOP,  C_ALWAYS,      ST_IDLE};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              take;

    assign ctrl   = rom_word(r_step);
    assign o_op   = ctrl.op;
    assign o_busy = (r_step != ST_IDLE);
    assign o_load = i_start && !o_busy;

    always_comb begin
        case (ctrl.cond)
            C_NONE:        take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_IDLE:        take = !i_start;
            C_DIV_MORE:    take = !i_stat.div_last;
            C_QUO_NZ:      take = i_stat.quo_nz;
            C_STACK_EMPTY: take = !i_stat.stack_nz;
            default:       take = 1'b0;
        endcase
        n_step = take ? ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* rtl/itrd_dp.sv */
// Datapath: base register, sign/magnitude load, 8-bit-per-cycle divider, digit stack, output word.
// Depends on itrd_pkg; driven by the op field of the sequencer's control word.
module itrd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic                              i_base_we,
    input  logic [itrd_pkg::BASE_W-1:0]       i_base_wdata,
    input  logic [itrd_pkg::VALUE_WIDTH-1:0]  i_value,
    input  itrd_pkg::t_op                     i_op,
    output itrd_pkg::t_stat                   o_stat,
    output logic                              o_valid,
    output logic [itrd_pkg::DIGIT_W-1:0]      o_digit,
    output logic                              o_negative,
    output logic                              o_last
);
    import itrd_pkg::*;

    logic [BASE_W-1:0]  r_base;
    logic [BASE_W-1:0]  r_div;
    logic [QUO_W-1:0]   r_quo;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIVC_W-1:0]  r_divc;
    logic [SP_W-1:0]    r_sp;
    logic               r_neg;
    logic [DIGIT_W-1:0] r_rdata;
    logic               r_valid;
    logic [DIGIT_W-1:0] r_digit;
    logic               r_negative;
    logic               r_last;
    logic [DIGIT_W-1:0] mem [DIG_MAX];

    logic [BASE_W-1:0]      eff_base;
    logic [VALUE_WIDTH-1:0] neg_val;
    logic [VALUE_WIDTH-1:0] mag_full;
    logic [QUO_W-1:0]       d_quo;
    logic [REM_W-1:0]       d_rem;
    logic [REM_W-1:0]       d_shift;
    logic [SP_W-1:0]        sp_dec;
    logic                   div_last;

    // Clamp the register into the supported radix range.
    always_comb begin
        if (r_base < BASE_MIN) begin
            eff_base = BASE_MIN;
        end else if (r_base > BASE_MAX) begin
            eff_base = BASE_MAX;
        end else begin
            eff_base = r_base;
        end
    end

    // Magnitude of the input; the most negative value saturates.
    always_comb begin
        neg_val = ~i_value + 1'b1;
        if (!i_value[VALUE_WIDTH-1]) begin
            mag_full = i_value;
        end else if (i_value == SIGN_ONLY) begin
            mag_full = POS_MAX;
        end else begin
            mag_full = neg_val;
        end
    end

    // Eight restoring steps of long division by the base.
    always_comb begin
        d_rem   = {1'b0, r_rem};
        d_quo   = r_quo;
        d_shift = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            d_shift = {d_rem[REM_W-2:0], d_quo[QUO_W-1]};
            d_quo   = {d_quo[QUO_W-2:0], 1'b0};
            if (d_shift >= r_div) begin
                d_shift  = d_shift - r_div;
                d_quo[0] = 1'b1;
            end
            d_rem = d_shift;
        end
    end

    assign sp_dec          = r_sp - 1'b1;
    assign div_last        = (r_divc == DIVC_W'(DIV_STEPS - 1));
    assign o_stat.div_last = div_last;
    assign o_stat.quo_nz   = |r_quo;
    assign o_stat.stack_nz = (r_sp != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_divc  <= '0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_base_we) begin
                r_base <= i_base_wdata;
            end
            r_valid <= (i_op == OP_EMIT);
            if (i_load) begin
                r_divc <= '0;
                r_sp   <= '0;
            end else begin
                case (i_op)
                    OP_DIV:  r_divc <= div_last ? '0 : r_divc + 1'b1;
                    OP_PUSH: r_sp   <= r_sp + 1'b1;
                    OP_POP:  r_sp   <= sp_dec;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= QUO_W'(mag_full[MAG_W-1:0]);
            r_rem <= '0;
            r_div <= eff_base;
            r_neg <= i_value[VALUE_WIDTH-1];
        end else begin
            case (i_op)
                OP_DIV: begin
                    r_quo <= d_quo;
                    r_rem <= d_rem[DIGIT_W-1:0];
                end
                OP_PUSH: r_rem <= '0;
                OP_EMIT: begin
                    r_digit    <= r_rdata;
                    r_negative <= r_neg;
                    r_last     <= (r_sp == '0);
                end
                default: ;
            endcase
        end
    end

    // Digit stack: push remainders, pop them most significant first.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_PUSH) begin
            mem[r_sp[ADDR_W-1:0]] <= r_rem;
        end
        if (i_op == OP_POP) begin
            r_rdata <= mem[sp_dec[ADDR_W-1:0]];
        end
    end

    assign o_valid    = r_valid;
    assign o_digit    = r_digit;
    assign o_negative = r_negative;
    assign o_last     = r_last;

endmodule

/* rtl/integer_to_radix_digits.sv */
// Top level of the signed integer to radix digit converter.
// Depends on itrd_pkg, itrd_seq and itrd_dp.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------------
//  input     | i_value                                 | taken when i_start && !o_busy
//  result    | o_digit, o_negative, o_last             | o_valid for one cycle, no stall
//  base reg  | i_base_wdata                            | written when i_base_we
//
// For each digit of the input in the selected base the run takes divider steps over the whole
// quotient register (eight quotient bits per cycle) plus one push, and each word leaves through a
// pop and an emit step; the word shows in the cycle after emit.
// o_busy is high from the cycle after a word is taken until the last digit is emitted.
// Synchronous active-low reset sets the base to ten and returns the sequencer to idle.
// The receiver cannot stall; every digit is shown for exactly one cycle.
module integer_to_radix_digits (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [itrd_pkg::VALUE_WIDTH-1:0]  i_value,
    input  logic                              i_base_we,
    input  logic [itrd_pkg::BASE_W-1:0]       i_base_wdata,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [itrd_pkg::DIGIT_W-1:0]      o_digit,
    output logic                              o_negative,
    output logic                              o_last
);
    import itrd_pkg::*;

    t_op   op;
    t_stat stat;
    logic  load;

    itrd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (o_busy),
        .o_load  (load)
    );

    itrd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_base_we    (i_base_we),
        .i_base_wdata (i_base_wdata),
        .i_value      (i_value),
        .i_op         (op),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_digit      (o_digit),
        .o_negative   (o_negative),
        .o_last       (o_last)
    );

endmodule

/* rtl/itrd_checker.sv */
// Port-level checks on the converter's run framing and reset behavior.
// Depends only on the top level's ports; bound to integer_to_radix_digits below.
module itrd_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic o_negative,
    input logic o_last
);

    // Reset leaves the block idle with no word on the output.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_busy && !o_valid))
        else $error("block not idle after reset");

    // A taken input starts a run.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("no run after accepted input");

    // Words never come back to back: each one needs a pop and an emit step.
    a_word_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two words in consecutive cycles");

    // A word that is not last keeps the block busy.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("idle with digits still pending");

    // The next digit follows after the next pop and emit steps, with the same sign.
    a_next_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> ##1 (o_valid && (o_negative == $past(o_negative, 2))))
        else $error("digit missing or sign changed within a run");

endmodule

bind integer_to_radix_digits itrd_props u_itrd_props (.*);
